// ===== rtl/fsc_pkg.sv =====
package fsc_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned LenWidth  = 8;

  localparam logic [LenWidth-1:0] MinLength   = 8'd8;
  localparam logic [LenWidth-1:0] CheckBytes  = 8'd4;
  localparam logic [LenWidth-1:0] SyncBytes   = 8'd4;
  localparam logic [LenWidth-1:0] MaxCount    = 8'hff;

  localparam logic [WordWidth-1:0] SyncWordReset   = 32'haa44121c;
  localparam logic [WordWidth-1:0] CrcPolyReset    = 32'hedb88320;
  localparam logic [LenWidth-1:0]  FrameLengthReset = 8'd112;

  localparam logic [1:0] REG_SYNC_WORD    = 2'd0;
  localparam logic [1:0] REG_CRC_POLY     = 2'd1;
  localparam logic [1:0] REG_FRAME_LENGTH = 2'd2;

  localparam logic [1:0] KIND_SYNC  = 2'd0;
  localparam logic [1:0] KIND_CRC   = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;

  typedef struct packed {
    logic [WordWidth-1:0] sync_word;
    logic [WordWidth-1:0] crc_polynomial;
    logic [LenWidth-1:0]  frame_length;
  } fsc_cfg_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic                 last;
    logic [WordWidth-1:0] data;
  } fsc_entry_t;

  typedef struct packed {
    logic                 crc_ok;
    logic [WordWidth-1:0] computed_crc;
    logic [WordWidth-1:0] received_crc;
  } fsc_result_t;

  function automatic logic [WordWidth-1:0] crc_byte(
    input logic [WordWidth-1:0] crc_in,
    input logic [ByteWidth-1:0] b,
    input logic [WordWidth-1:0] poly
  );
    logic [WordWidth-1:0] c;
    c = crc_in ^ {{(WordWidth-ByteWidth){1'b0}}, b};
    for (int k = 0; k < ByteWidth; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/fsc_fifo.sv =====
module fsc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCount = CntWidth'(DEPTH);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == FullCount);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/fsc_front.sv =====
module fsc_front (
  input  logic               clk,
  input  logic               rst,
  input  fsc_pkg::fsc_cfg_t  cfg,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  output logic               enq,
  output fsc_pkg::fsc_entry_t entry
);
  import fsc_pkg::*;

  logic [WordWidth-1:0] sync_shift;
  logic [WordWidth-1:0] sync_shift_next;
  logic                 in_frame;
  logic [LenWidth-1:0]  byte_count;
  logic [LenWidth-1:0]  count_inc;
  logic [LenWidth-1:0]  len;
  logic                 match;
  logic                 frame_end;

  assign len             = (cfg.frame_length < MinLength) ? MinLength : cfg.frame_length;
  assign sync_shift_next = {sync_shift[WordWidth-ByteWidth-1:0], data_byte};
  assign match           = !in_frame && (sync_shift_next == cfg.sync_word);
  assign count_inc       = (byte_count < MaxCount) ? byte_count + 1'b1 : byte_count;
  assign frame_end       = in_frame && (count_inc >= len);

  always_comb begin
    enq        = accept && (in_frame || match);
    entry.last = frame_end;
    if (!in_frame) begin
      entry.kind = KIND_SYNC;
      entry.data = sync_shift_next;
    end else begin
      entry.kind = (byte_count < len - CheckBytes) ? KIND_CRC : KIND_CHECK;
      entry.data = {{(WordWidth-ByteWidth){1'b0}}, data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_shift <= '0;
      in_frame   <= 1'b0;
      byte_count <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        sync_shift <= sync_shift_next;
        if (match) begin
          in_frame   <= 1'b1;
          byte_count <= SyncBytes;
        end
      end else if (frame_end) begin
        in_frame   <= 1'b0;
        sync_shift <= '0;
        byte_count <= '0;
      end else begin
        byte_count <= count_inc;
      end
    end
  end

endmodule

// ===== rtl/fsc_back.sv =====
module fsc_back (
  input  logic                clk,
  input  logic                rst,
  input  fsc_pkg::fsc_cfg_t   cfg,
  input  logic                mid_empty,
  input  fsc_pkg::fsc_entry_t entry,
  output logic                mid_pop,
  input  logic                res_full,
  output logic                res_push,
  output fsc_pkg::fsc_result_t result
);
  import fsc_pkg::*;

  logic [WordWidth-1:0] crc_accum;
  logic [WordWidth-1:0] crc_accum_next;
  logic [WordWidth-1:0] checksum_accum;
  logic [WordWidth-1:0] checksum_accum_next;
  logic [23:0]          sync_rest;
  logic [1:0]           steps;

  always_comb begin
    crc_accum_next      = crc_accum;
    checksum_accum_next = checksum_accum;
    mid_pop             = 1'b0;
    res_push            = 1'b0;
    if (steps != 2'd0) begin
      crc_accum_next = crc_byte(crc_accum, sync_rest[23:16], cfg.crc_polynomial);
    end else if (!mid_empty && !(entry.last && res_full)) begin
      mid_pop  = 1'b1;
      res_push = entry.last;
      unique case (entry.kind)
        KIND_SYNC: begin
          crc_accum_next      = crc_byte('0, entry.data[31:24], cfg.crc_polynomial);
          checksum_accum_next = '0;
        end
        KIND_CRC: begin
          crc_accum_next = crc_byte(crc_accum, entry.data[7:0], cfg.crc_polynomial);
        end
        KIND_CHECK: begin
          checksum_accum_next = {entry.data[7:0], checksum_accum[WordWidth-1:ByteWidth]};
        end
        default: begin
        end
      endcase
    end
    result.crc_ok       = (crc_accum_next == checksum_accum_next);
    result.computed_crc = crc_accum_next;
    result.received_crc = checksum_accum_next;
  end

  always_ff @(posedge clk) begin
    crc_accum      <= crc_accum_next;
    checksum_accum <= checksum_accum_next;
    if (steps != 2'd0) begin
      sync_rest <= {sync_rest[15:0], 8'h00};
    end else if (mid_pop && entry.kind == KIND_SYNC) begin
      sync_rest <= entry.data[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= 2'd0;
    end else if (steps != 2'd0) begin
      steps <= steps - 2'd1;
    end else if (mid_pop && entry.kind == KIND_SYNC) begin
      steps <= 2'd3;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_in_sync: assert property (@(posedge clk) disable iff (rst)
    steps != 2'd0 |-> !mid_pop)
    else $error("queue popped while sync bytes are still being folded in");

  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (mid_pop && entry.last))
    else $error("result pushed for a beat that does not end a frame");

  a_sync_steps: assert property (@(posedge clk) disable iff (rst)
    (mid_pop && entry.kind == KIND_SYNC) |=> steps == 2'd3)
    else $error("sync beat did not start the three-byte sync fold");

  a_no_result_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");
`endif

endmodule

// ===== rtl/frame_sync_crc32_check_core.sv =====
// Channel  | Handshake                 | Payload
// -------- | ------------------------- | -------------------------------------------
// input    | push / full               | data_byte[7:0]
// result   | empty / pop               | crc_ok, computed_crc[31:0], received_crc[31:0]
// config   | cfg_valid / cfg_ready     | cfg_index[1:0], cfg_data[31:0]
//
// One byte beat is taken per cycle while the middle queue has room.
// The back end takes one byte per cycle while the middle queue holds entries,
// folding payload bytes into the CRC and shifting check bytes into received_crc;
// after a sync match it first folds in the other sync bytes the front took while
// hunting, and this fold can fill the middle queue and raise full after a match.
// Results wait in a small output queue, and the back end stalls only when a frame
// ends while that queue is full. rst is synchronous and restores the register
// defaults; cfg_ready is always high.
module frame_sync_crc32_check_core #(
  parameter int unsigned QUEUE_DEPTH  = 4,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic        crc_ok,
  output logic [31:0] computed_crc,
  output logic [31:0] received_crc,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fsc_pkg::*;

  fsc_cfg_t    cfg;
  fsc_entry_t  enq_entry;
  fsc_entry_t  mid_entry;
  fsc_result_t res_in;
  fsc_result_t res_out;
  logic        accept;
  logic        enq;
  logic        mid_full;
  logic        mid_empty;
  logic        mid_pop;
  logic        res_full;
  logic        res_push;

  assign cfg_ready = 1'b1;
  assign full      = mid_full;
  assign accept    = push && !mid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_word      <= SyncWordReset;
      cfg.crc_polynomial <= CrcPolyReset;
      cfg.frame_length   <= FrameLengthReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SYNC_WORD:    cfg.sync_word      <= cfg_data;
        REG_CRC_POLY:     cfg.crc_polynomial <= cfg_data;
        REG_FRAME_LENGTH: cfg.frame_length   <= cfg_data[LenWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  fsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (data_byte),
    .enq       (enq),
    .entry     (enq_entry)
  );

  fsc_fifo #(
    .WIDTH ($bits(fsc_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (enq),
    .wdata (enq_entry),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_entry),
    .empty (mid_empty)
  );

  fsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .entry     (mid_entry),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .result    (res_in)
  );

  fsc_fifo #(
    .WIDTH ($bits(fsc_result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign crc_ok       = res_out.crc_ok;
  assign computed_crc = res_out.computed_crc;
  assign received_crc = res_out.received_crc;

endmodule
